FILE: src/tns_pkg.sv
// Package for the timed note sequencer: item types, op codes, priorities.
// No dependencies.
package tns_pkg;

  localparam int NOTE_DEPTH_DEF = 1024;
  localparam int TRACK_COUNT_DEF = 16;
  localparam int SLOT_COUNT_DEF = 4;
  localparam int NOTES_PER_SLOT_TICK_DEF = 16;
  localparam int RESULT_CAP = 64;
  localparam logic [23:0] TIME_MAX = 24'hFFFFFF;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_DEFINE = 3'd1;
  localparam logic [2:0] OP_MUSIC = 3'd2;
  localparam logic [2:0] OP_EFFECT = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic [1:0] PRI_LOW = 2'd0;
  localparam logic [1:0] PRI_MEDIUM = 2'd1;
  localparam logic [1:0] PRI_HIGH = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  track_id;
    logic [9:0]  note_addr;
    logic [10:0] note_count;
    logic [23:0] start_time;
    logic [15:0] duration;
    logic [1:0]  voice;
    logic [15:0] frequency;
    logic [7:0]  wave_mode;
    logic [1:0]  loudness;
    logic        high_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_voice;
    logic [15:0] out_duration;
    logic [15:0] out_frequency;
    logic [7:0]  out_mode;
    logic [1:0]  out_loudness;
    logic [1:0]  out_priority;
    logic [1:0]  out_slot;
    logic        last;
  } out_item_t;

endpackage

FILE: src/tns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: src/tns_front.sv
// Front end: input queue stage, two-entry queue towards the back end.
// Depends on tns_pkg.
module tns_front import tns_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_take
);
  in_item_t   buf_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic       push_ok;
  logic       known;

  // drop unknown ops here so the back end sees only real work
  always_comb begin
    known = in_data.op inside {OP_LOAD, OP_DEFINE, OP_MUSIC, OP_EFFECT, OP_TICK};
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full && known;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_take && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, q_take && q_valid};
    end
    if (push_ok) begin
      buf_r[wr_ptr_r] <= in_data;
    end
  end
endmodule

FILE: src/tns_back.sv
// Back end: note store, track table, slot sequencer and result register.
// Depends on tns_pkg and tns_ram.
module tns_back import tns_pkg::*; #(
  parameter int NOTE_DEPTH = NOTE_DEPTH_DEF,
  parameter int TRACK_COUNT = TRACK_COUNT_DEF,
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int NOTES_PER_SLOT_TICK = NOTES_PER_SLOT_TICK_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_take,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);
  localparam int AW = $clog2(NOTE_DEPTH);
  localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int LW = AW + 1;
  localparam int KW = $clog2(NOTES_PER_SLOT_TICK + 1);
  localparam int NW = $clog2(RESULT_CAP + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SLOT  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] trk_start_r [TRACK_COUNT];
  logic [LW-1:0] trk_len_r [TRACK_COUNT];
  logic [TRACK_COUNT-1:0] trk_valid_r;
  logic [SLOT_COUNT-1:0] s_active_r;
  logic [TW-1:0] s_track_r [SLOT_COUNT];
  logic [LW-1:0] s_next_r [SLOT_COUNT];
  logic [LW-1:0] s_end_r [SLOT_COUNT];
  logic [23:0] s_time_r [SLOT_COUNT];
  logic [1:0] s_pri_r [SLOT_COUNT];
  logic tick_phase_r;

  logic [SW-1:0] cur_r;
  logic [KW-1:0] k_r;
  logic [NW-1:0] n_r;
  out_item_t held_r;
  logic held_v_r;
  out_item_t out_r;
  logic out_v_r;

  logic [23:0] rd_time;
  logic [43:0] rd_sound;
  logic [AW-1:0] rd_addr;
  logic ram_we;
  logic [AW-1:0] wr_addr;

  logic trk_ok;
  logic [TW-1:0] trk_idx;
  logic [LW-1:0] cnt_sat;
  logic [1:0] eff_pri;
  logic slot_found;
  logic [SW-1:0] slot_sel;
  logic can_more;
  logic out_free;
  logic last_slot;
  logic load_out;
  out_item_t fin_item;

  assign trk_idx = TW'(q_item.track_id);
  assign trk_ok = (32'(q_item.track_id) < TRACK_COUNT);
  assign cnt_sat = (32'(q_item.note_count) > 32'(NOTE_DEPTH)) ? LW'(NOTE_DEPTH)
                                                           : LW'(q_item.note_count);
  assign eff_pri = q_item.high_priority ? PRI_HIGH : PRI_MEDIUM;
  assign wr_addr = AW'(q_item.note_addr);
  assign ram_we = (state_r == ST_IDLE) && q_valid && (q_item.op == OP_LOAD);
  assign rd_addr = trk_start_r[s_track_r[cur_r]] + s_next_r[cur_r][AW-1:0];
  assign last_slot = (cur_r == SW'(SLOT_COUNT - 1));
  assign can_more = (s_next_r[cur_r] < s_end_r[cur_r]) &&
                    (32'(k_r) < NOTES_PER_SLOT_TICK) && (32'(n_r) < RESULT_CAP);
  assign out_free = !out_v_r || out_pop;
  assign load_out = held_v_r && out_free &&
                    ((state_r == ST_EMIT) || (state_r == ST_FIN));

  always_comb begin
    fin_item = held_r;
    fin_item.last = 1'b1;
  end

  always_comb begin
    slot_found = 1'b0;
    slot_sel = '0;
    for (int s = SLOT_COUNT - 1; s >= 1; s--) begin
      if (s_pri_r[s] < eff_pri) begin
        slot_found = 1'b1;
        slot_sel = SW'(s);
      end
    end
  end

  tns_ram #(.WIDTH(24), .DEPTH(NOTE_DEPTH)) u_time (
    .clk(clk), .wr_en(ram_we), .wr_addr(wr_addr), .wr_data(q_item.start_time),
    .rd_addr(rd_addr), .rd_data(rd_time)
  );

  tns_ram #(.WIDTH(44), .DEPTH(NOTE_DEPTH)) u_sound (
    .clk(clk), .wr_en(ram_we), .wr_addr(wr_addr),
    .wr_data({q_item.loudness, q_item.wave_mode, q_item.frequency,
              q_item.voice, q_item.duration}),
    .rd_addr(rd_addr), .rd_data(rd_sound)
  );

  // take an item only in idle, and only when nothing is held back
  assign q_take = (state_r == ST_IDLE) && q_valid && !held_v_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_take && q_item.op == OP_TICK && tick_phase_r) begin
          state_nxt = ST_SLOT;
        end
      end
      ST_SLOT:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (can_more && rd_time <= s_time_r[cur_r]) begin
          state_nxt = ST_EMIT;
        end else if (last_slot) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SLOT;
        end
      end
      ST_EMIT: begin
        if (!held_v_r || out_free) begin
          state_nxt = ST_READ;
        end
      end
      ST_FIN: begin
        if (!held_v_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      trk_valid_r <= '0;
      s_active_r <= '0;
      tick_phase_r <= 1'b0;
      cur_r <= '0;
      k_r <= '0;
      n_r <= '0;
      held_v_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        s_track_r[s] <= '0;
        s_next_r[s] <= '0;
        s_end_r[s] <= '0;
        s_time_r[s] <= '0;
        s_pri_r[s] <= PRI_LOW;
      end
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_take) begin
            case (q_item.op)
              OP_DEFINE: begin
                if (trk_ok) begin
                  trk_start_r[trk_idx] <= wr_addr;
                  trk_len_r[trk_idx] <= cnt_sat;
                  trk_valid_r[trk_idx] <= 1'b1;
                end
              end
              OP_MUSIC: begin
                if (trk_ok && trk_valid_r[trk_idx] &&
                    !(s_active_r[0] && s_track_r[0] == trk_idx)) begin
                  s_active_r[0] <= 1'b1;
                  s_track_r[0] <= trk_idx;
                  s_next_r[0] <= '0;
                  s_end_r[0] <= trk_len_r[trk_idx];
                  s_time_r[0] <= '0;
                  s_pri_r[0] <= PRI_LOW;
                end
              end
              OP_EFFECT: begin
                if (trk_ok && trk_valid_r[trk_idx] && slot_found) begin
                  s_active_r[slot_sel] <= 1'b1;
                  s_track_r[slot_sel] <= trk_idx;
                  s_next_r[slot_sel] <= '0;
                  s_end_r[slot_sel] <= trk_len_r[trk_idx];
                  s_time_r[slot_sel] <= '0;
                  s_pri_r[slot_sel] <= eff_pri;
                end
              end
              OP_TICK: begin
                tick_phase_r <= ~tick_phase_r;
                cur_r <= '0;
                n_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SLOT: begin
          k_r <= '0;
          if (s_active_r[cur_r] && s_time_r[cur_r] != TIME_MAX) begin
            s_time_r[cur_r] <= s_time_r[cur_r] + 24'd1;
          end
        end
        ST_CHECK: begin
          if (!(s_active_r[cur_r] && can_more && rd_time <= s_time_r[cur_r])) begin
            // slot done for this tick: release it if the track is played out
            if (s_active_r[cur_r] && s_next_r[cur_r] >= s_end_r[cur_r]) begin
              s_active_r[cur_r] <= 1'b0;
              s_pri_r[cur_r] <= PRI_LOW;
            end
            if (!last_slot) begin
              cur_r <= cur_r + SW'(1);
            end
          end
        end
        ST_EMIT: begin
          if (!held_v_r || out_free) begin
            // push the held note out, hold the new one until the next is known
            if (held_v_r) begin
              out_r <= held_r;
            end
            held_r <= '{out_voice: rd_sound[17:16], out_duration: rd_sound[15:0],
                        out_frequency: rd_sound[33:18], out_mode: rd_sound[41:34],
                        out_loudness: rd_sound[43:42], out_priority: s_pri_r[cur_r],
                        out_slot: 2'(cur_r), last: 1'b0};
            held_v_r <= 1'b1;
            s_next_r[cur_r] <= s_next_r[cur_r] + LW'(1);
            k_r <= k_r + KW'(1);
            n_r <= n_r + NW'(1);
          end
        end
        ST_FIN: begin
          if (held_v_r && out_free) begin
            out_r <= fin_item;
            held_v_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_empty = !out_v_r;
  assign out_data = out_r;
endmodule

FILE: src/timed_note_sequencer.sv
// Top level of the timed note sequencer: front queue and back-end sequencer.
// Depends on tns_pkg, tns_front and tns_back.
//
// Load, define, play and non-advancing tick transactions are taken by the
// back end one per cycle while it is idle; each passes the front queue
// register before it takes effect. A tick on an advancing phase walks every
// slot through the slot, read and check states and each emitted note through
// the emit, read and check states of the note store read loop, ending in the
// fin state; output back-pressure can stall it. It emits at most 64 notes and
// no further item is taken meanwhile. Notes are delivered one note behind in
// a hold register so the last flag can mark the final note of each tick.
module timed_note_sequencer import tns_pkg::*; #(
  parameter int NOTE_DEPTH = NOTE_DEPTH_DEF,
  parameter int TRACK_COUNT = TRACK_COUNT_DEF,
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int NOTES_PER_SLOT_TICK = NOTES_PER_SLOT_TICK_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);
  logic     q_valid, q_take;
  in_item_t q_item;

  tns_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  tns_back #(
    .NOTE_DEPTH(NOTE_DEPTH), .TRACK_COUNT(TRACK_COUNT),
    .SLOT_COUNT(SLOT_COUNT), .NOTES_PER_SLOT_TICK(NOTES_PER_SLOT_TICK)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );
endmodule
